[hdl/assert_macros.svh]
// Assertion macros shared by the reservation table RTL.
// Each macro expects signals named clock and reset in the scope of its use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define SIRT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// The expression must never be true at a rising clock edge outside reset.
`define SIRT_ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

[hdl/sirt_pkg.sv]
// Types, codes and the time check for the sorted interval reservation table.
// No dependencies; the store and the table refer to it by scoped names.
package sirt_pkg;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_FIND   = 2'd2,
      OP_RSVD   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      STAT_OK       = 3'd0,
      STAT_ILLEGAL  = 3'd1,
      STAT_OVERLAP  = 3'd2,
      STAT_FULL     = 3'd3,
      STAT_NOTFOUND = 3'd4,
      STAT_EMPTY    = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      CSR_HOUR_LO   = 2'd0,
      CSR_HOUR_HI   = 2'd1,
      CSR_MINUTE_LO = 2'd2,
      CSR_MINUTE_HI = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT_UP,
      ST_SHIFT_DN,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [11:0]        start_time;
      logic [11:0]        end_time;
      logic signed [7:0]  room;
   } entry_type;

   localparam logic [4:0] HOUR_LO_RST   = 5'd0;
   localparam logic [4:0] HOUR_HI_RST   = 5'd24;
   localparam logic [5:0] MINUTE_LO_RST = 6'd0;
   localparam logic [5:0] MINUTE_HI_RST = 6'd60;

   // t/100 equals (t*5243)>>19 exactly for every 12-bit t.
   localparam logic [12:0] DIV100_MUL = 13'd5243;
   localparam logic [12:0] HUNDRED    = 13'd100;

   function automatic logic time_valid(input logic [11:0] t,
                                       input logic [4:0]  min_h,
                                       input logic [4:0]  max_h,
                                       input logic [5:0]  min_m,
                                       input logic [5:0]  max_m);
      logic [24:0] prod;
      logic [5:0]  hr;
      logic [12:0] hund;
      logic [11:0] rem;
      logic [6:0]  mn;
      prod = {13'd0, t} * {12'd0, DIV100_MUL};
      hr   = prod[24:19];
      hund = {7'd0, hr} * HUNDRED;
      rem  = t - hund[11:0];
      mn   = rem[6:0];
      return (hr >= {1'b0, min_h}) && (hr < {1'b0, max_h}) &&
             (mn >= {1'b0, min_m}) && (mn < {1'b0, max_m});
   endfunction

endpackage

[hdl/sirt_req_if.sv]
// Request channel of the reservation table: valid/ready handshake and one operation.
// Depends on nothing.
interface sirt_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         op;
   logic [11:0]        start_time;
   logic [11:0]        end_time;
   logic signed [7:0]  room;

   modport source (output valid, output op, output start_time, output end_time,
                   output room, input ready);
   modport sink   (input valid, input op, input start_time, input end_time,
                   input room, output ready);
endinterface

[hdl/sirt_rsp_if.sv]
// Response channel of the reservation table: valid/ready handshake and one result.
// Depends on nothing.
interface sirt_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic [3:0]         position;
   logic [11:0]        found_end;
   logic signed [7:0]  found_room;

   modport source (output valid, output status, output position, output found_end,
                   output found_room, input ready);
   modport sink   (input valid, input status, input position, input found_end,
                   input found_room, output ready);
endinterface

[hdl/sirt_store.sv]
// Entry memory of the reservation table: one write port, one registered read port.
// Depends on sirt_pkg for the entry type.
module sirt_store #(
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       we,
   input  logic [$clog2(DEPTH)-1:0]   waddr,
   input  sirt_pkg::entry_type        wdata,
   input  logic [$clog2(DEPTH)-1:0]   raddr,
   output sirt_pkg::entry_type        rdata
);

   sirt_pkg::entry_type mem [DEPTH];
   sirt_pkg::entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[hdl/sorted_interval_reservation_table.sv]
// Sorted interval reservation table: keeps up to CAPACITY intervals ordered by start
// and checks every insert against all of them. One operation is handled at a time
// through an entry memory with one write port and one registered read port that is
// read once per cycle. An illegal request, an unused op code, or a find or remove on
// an empty table goes straight to the response; a find stops at the matching entry
// or after all n stored entries; an insert stops at the first overlapping entry,
// answers full after scanning a full table, and otherwise shifts the entries above
// its position up and writes itself there; a remove stops at the matching entry and
// shifts the entries above it down. A response that has not been taken yet holds the
// block in its last cycle until it is.
`include "assert_macros.svh"

module sorted_interval_reservation_table #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [5:0]  csr_wdata,
   sirt_req_if.sink    req,
   sirt_rsp_if.source  rsp
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE     = CW'(1);

   logic [4:0] hour_lo_ff, hour_hi_ff;
   logic [5:0] minute_lo_ff, minute_hi_ff;

   sirt_pkg::state_type  state_ff, state_in;
   sirt_pkg::op_type     op_ff, op_in;
   sirt_pkg::status_type res_ff, res_in;
   logic [11:0]          s_ff, s_in, e_ff, e_in;
   logic signed [7:0]    room_ff, room_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        iss_ff, iss_in, iss_dec;
   logic                 rd_vld_ff, rd_vld_in;
   logic [IW-1:0]        chk_ff, chk_in;
   logic [CW-1:0]        pos_ff, pos_in;
   logic [11:0]          fe_ff, fe_in;
   logic signed [7:0]    fr_ff, fr_in;
   logic [31:0]          pos_wide;

   logic                 rsp_vld_ff, rsp_vld_in;
   logic [2:0]           rsp_status_ff, rsp_status_in;
   logic [3:0]           rsp_pos_ff, rsp_pos_in;
   logic [11:0]          rsp_end_ff, rsp_end_in;
   logic signed [7:0]    rsp_room_ff, rsp_room_in;

   logic                 mem_we;
   logic [IW-1:0]        mem_wa, mem_ra;
   sirt_pkg::entry_type  mem_wd, mem_rd;
   logic                 tv_s, tv_e;
   logic                 in_shift, op_ended;

   sirt_store #(.DEPTH(CAPACITY)) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_wa),
      .wdata (mem_wd),
      .raddr (mem_ra),
      .rdata (mem_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         hour_lo_ff   <= sirt_pkg::HOUR_LO_RST;
         hour_hi_ff   <= sirt_pkg::HOUR_HI_RST;
         minute_lo_ff <= sirt_pkg::MINUTE_LO_RST;
         minute_hi_ff <= sirt_pkg::MINUTE_HI_RST;
      end else if (csr_we) begin
         case (csr_index)
            sirt_pkg::CSR_HOUR_LO:   hour_lo_ff   <= csr_wdata[4:0];
            sirt_pkg::CSR_HOUR_HI:   hour_hi_ff   <= csr_wdata[4:0];
            sirt_pkg::CSR_MINUTE_LO: minute_lo_ff <= csr_wdata;
            sirt_pkg::CSR_MINUTE_HI: minute_hi_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign tv_s = sirt_pkg::time_valid(req.start_time, hour_lo_ff, hour_hi_ff,
                                      minute_lo_ff, minute_hi_ff);
   assign tv_e = sirt_pkg::time_valid(req.end_time, hour_lo_ff, hour_hi_ff,
                                      minute_lo_ff, minute_hi_ff);
   assign iss_dec  = iss_ff - ONE;
   assign pos_wide = 32'(pos_ff);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      res_in        = res_ff;
      s_in          = s_ff;
      e_in          = e_ff;
      room_in       = room_ff;
      count_in      = count_ff;
      iss_in        = iss_ff;
      rd_vld_in     = 1'b0;
      chk_in        = chk_ff;
      pos_in        = pos_ff;
      fe_in         = fe_ff;
      fr_in         = fr_ff;
      rsp_vld_in    = rsp_vld_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_room_in   = rsp_room_ff;
      mem_we        = 1'b0;
      mem_wa        = chk_ff;
      mem_wd        = mem_rd;
      mem_ra        = iss_ff[IW-1:0];
      req.ready     = 1'b0;

      case (state_ff)
         sirt_pkg::ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               op_in   = sirt_pkg::op_type'(req.op);
               s_in    = req.start_time;
               e_in    = req.end_time;
               room_in = req.room;
               pos_in  = '0;
               fe_in   = '0;
               fr_in   = '0;
               iss_in  = '0;
               case (sirt_pkg::op_type'(req.op))
                  sirt_pkg::OP_INSERT: begin
                     if (tv_s && tv_e && (req.end_time > req.start_time) &&
                         (req.room > 8'sd0)) begin
                        state_in = sirt_pkg::ST_SCAN;
                     end else begin
                        res_in   = sirt_pkg::STAT_ILLEGAL;
                        state_in = sirt_pkg::ST_RESP;
                     end
                  end
                  sirt_pkg::OP_REMOVE, sirt_pkg::OP_FIND: begin
                     if (count_ff == '0) begin
                        res_in   = sirt_pkg::STAT_EMPTY;
                        state_in = sirt_pkg::ST_RESP;
                     end else begin
                        state_in = sirt_pkg::ST_SCAN;
                     end
                  end
                  default: begin
                     res_in   = sirt_pkg::STAT_ILLEGAL;
                     state_in = sirt_pkg::ST_RESP;
                  end
               endcase
            end
         end

         // One entry is read per cycle; its compare runs in the cycle after.
         sirt_pkg::ST_SCAN: begin
            if (iss_ff < count_ff) begin
               rd_vld_in = 1'b1;
               chk_in    = iss_ff[IW-1:0];
               iss_in    = iss_ff + ONE;
            end
            if (rd_vld_ff) begin
               if (op_ff == sirt_pkg::OP_INSERT) begin
                  if ((mem_rd.start_time < e_ff) && (mem_rd.end_time > s_ff)) begin
                     res_in    = sirt_pkg::STAT_OVERLAP;
                     pos_in    = '0;
                     rd_vld_in = 1'b0;
                     state_in  = sirt_pkg::ST_RESP;
                  end else if (mem_rd.start_time <= s_ff) begin
                     pos_in = pos_ff + ONE;
                  end
               end else if (mem_rd.start_time == s_ff) begin
                  pos_in    = CW'(chk_ff);
                  fe_in     = mem_rd.end_time;
                  fr_in     = mem_rd.room;
                  rd_vld_in = 1'b0;
                  if (op_ff == sirt_pkg::OP_FIND) begin
                     res_in   = sirt_pkg::STAT_OK;
                     state_in = sirt_pkg::ST_RESP;
                  end else begin
                     iss_in   = CW'(chk_ff) + ONE;
                     state_in = sirt_pkg::ST_SHIFT_DN;
                  end
               end
            end else if (iss_ff == count_ff) begin
               if (op_ff != sirt_pkg::OP_INSERT) begin
                  res_in   = sirt_pkg::STAT_NOTFOUND;
                  state_in = sirt_pkg::ST_RESP;
               end else if (count_ff == CAP_CNT) begin
                  res_in   = sirt_pkg::STAT_FULL;
                  pos_in   = '0;
                  state_in = sirt_pkg::ST_RESP;
               end else begin
                  iss_in   = count_ff;
                  state_in = sirt_pkg::ST_SHIFT_UP;
               end
            end
         end

         // Entries from the top down to the insert position move up by one.
         sirt_pkg::ST_SHIFT_UP: begin
            if (iss_ff > pos_ff) begin
               mem_ra    = iss_dec[IW-1:0];
               rd_vld_in = 1'b1;
               chk_in    = iss_ff[IW-1:0];
               iss_in    = iss_dec;
            end
            if (rd_vld_ff) begin
               mem_we = 1'b1;
            end else if (iss_ff == pos_ff) begin
               mem_we            = 1'b1;
               mem_wa            = pos_ff[IW-1:0];
               mem_wd.start_time = s_ff;
               mem_wd.end_time   = e_ff;
               mem_wd.room       = room_ff;
               count_in          = count_ff + ONE;
               res_in            = sirt_pkg::STAT_OK;
               state_in          = sirt_pkg::ST_RESP;
            end
         end

         // Entries above the removed one move down by one.
         sirt_pkg::ST_SHIFT_DN: begin
            if (iss_ff < count_ff) begin
               rd_vld_in = 1'b1;
               chk_in    = iss_dec[IW-1:0];
               iss_in    = iss_ff + ONE;
            end
            if (rd_vld_ff) begin
               mem_we = 1'b1;
            end else if (iss_ff == count_ff) begin
               count_in = count_ff - ONE;
               res_in   = sirt_pkg::STAT_OK;
               state_in = sirt_pkg::ST_RESP;
            end
         end

         sirt_pkg::ST_RESP: begin
            if (!rsp_vld_ff || rsp.ready) begin
               rsp_vld_in    = 1'b1;
               rsp_status_in = res_ff;
               rsp_pos_in    = pos_wide[3:0];
               rsp_end_in    = fe_ff;
               rsp_room_in   = fr_ff;
               state_in      = sirt_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = sirt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= sirt_pkg::ST_IDLE;
         count_ff   <= '0;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         rd_vld_ff  <= rd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      res_ff        <= res_in;
      s_ff          <= s_in;
      e_ff          <= e_in;
      room_ff       <= room_in;
      iss_ff        <= iss_in;
      chk_ff        <= chk_in;
      pos_ff        <= pos_in;
      fe_ff         <= fe_in;
      fr_ff         <= fr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_end_ff    <= rsp_end_in;
      rsp_room_ff   <= rsp_room_in;
   end

   assign rsp.valid      = rsp_vld_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.position   = rsp_pos_ff;
   assign rsp.found_end  = rsp_end_ff;
   assign rsp.found_room = rsp_room_ff;

   assign in_shift = (state_ff == sirt_pkg::ST_SHIFT_UP) || (state_ff == sirt_pkg::ST_SHIFT_DN);
   assign op_ended = (state_ff == sirt_pkg::ST_IDLE) || (state_ff == sirt_pkg::ST_RESP);

   `SIRT_ASSERT(a_count_bound, count_ff <= CAP_CNT, "entry count above capacity")
   `SIRT_ASSERT(a_write_in_shift, mem_we |-> in_shift, "memory written outside a shift")
   `SIRT_ASSERT(a_count_hold, $stable(count_ff) || $past(in_shift || reset), "count changed")
   `SIRT_ASSERT_NEVER(a_no_stale_read, rd_vld_ff && op_ended, "stale read pending")

endmodule
